// File: src/ffxs_pkg.sv
// Shared types and constants for the fixed-length frame finder.
// No dependencies; used by ffxs_window and fixed_frame_xor_sync.
`timescale 1ns / 1ps
`default_nettype none

package ffxs_pkg;

  localparam int BYTE_W    = 8;
  localparam int POS_W     = 5;
  localparam int LEN_W     = 6;
  localparam int TAIL_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_HEADER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd2;

  localparam logic [BYTE_W-1:0] HEADER_RST = 8'd0;
  localparam logic [TAIL_W-1:0] TAIL_RST   = 16'd0;
  localparam logic [LEN_W-1:0]  LENGTH_RST = 6'd13;
  localparam logic [LEN_W-1:0]  MIN_LEN    = 6'd3;

  // control strobes from the sequencer to the window memory
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } win_ctl_t;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_CHECK   = 6'b000010,
    S_HDR     = 6'b000100,
    S_SCAN    = 6'b001000,
    S_EMIT_RD = 6'b010000,
    S_EMIT_WB = 6'b100000
  } state_t;

endpackage

`default_nettype wire

// File: src/ffxs_window.sv
// Byte window memory: circular store addressed by offset from the oldest slot.
// Depends on ffxs_pkg (win_ctl_t, BYTE_W).
`timescale 1ns / 1ps
`default_nettype none

module ffxs_window #(
  parameter int MAX_FRAME = 32,
  parameter int AW        = $clog2(MAX_FRAME),
  parameter int CW        = $clog2(MAX_FRAME + 1)
) (
  input  wire                            clk,
  input  wire  ffxs_pkg::win_ctl_t       ctl,
  input  wire  [AW-1:0]                  oldest_slot,
  input  wire  [CW-1:0]                  wr_off,
  input  wire  [ffxs_pkg::BYTE_W-1:0]    wr_data,
  input  wire  [CW-1:0]                  rd_off,
  output logic [ffxs_pkg::BYTE_W-1:0]    rd_data
);

  localparam int SW = CW + 1;

  logic [ffxs_pkg::BYTE_W-1:0] mem [MAX_FRAME];
  logic [SW-1:0] wr_sum, rd_sum;
  logic [AW-1:0] wr_addr, rd_addr;

  // oldest + offset stays below twice the depth: one compare and subtract
  assign wr_sum  = SW'(oldest_slot) + SW'(wr_off);
  assign rd_sum  = SW'(oldest_slot) + SW'(rd_off);
  assign wr_addr = (wr_sum >= SW'(MAX_FRAME)) ? AW'(wr_sum - SW'(MAX_FRAME)) : AW'(wr_sum);
  assign rd_addr = (rd_sum >= SW'(MAX_FRAME)) ? AW'(rd_sum - SW'(MAX_FRAME)) : AW'(rd_sum);

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: src/fixed_frame_xor_sync.sv
// Fixed-length frame finder: header byte match, XOR check byte, optional tail.
// Sequence: a byte is taken only while idle; with a valid length a search follows,
// testing each candidate start by its header and, on a header match, by a scan
// for the XOR check byte and the tail; a found frame then streams out byte by
// byte (window read, output load), held on a stall. Reset (synchronous,
// rst_n low): window empty, header 0, tail 0, length 13; contents not cleared.
`timescale 1ns / 1ps
`default_nettype none

module fixed_frame_xor_sync #(
  parameter int MAX_FRAME = 32
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // input bytes
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire  [ffxs_pkg::BYTE_W-1:0]        in_rx_byte,
  // frame bytes
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [ffxs_pkg::BYTE_W-1:0]        out_frame_byte,
  output logic [ffxs_pkg::POS_W-1:0]         out_byte_position,
  output logic                               out_frame_end,
  // configuration writes
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [ffxs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [ffxs_pkg::CFG_DAT_W-1:0]     cfg_data
);

  localparam int AW   = $clog2(MAX_FRAME);
  localparam int CW   = $clog2(MAX_FRAME + 1);
  // compare width: covers the fill count, the length register and MAX_FRAME
  localparam int CMPW = ((CW > ffxs_pkg::LEN_W) ? CW : ffxs_pkg::LEN_W) + 1;
  localparam int SW   = CW + 1;

  // configuration registers
  logic [ffxs_pkg::BYTE_W-1:0] header_r;
  logic [ffxs_pkg::TAIL_W-1:0] tail_r;
  logic [ffxs_pkg::LEN_W-1:0]  length_r;

  // window bookkeeping and sequencer
  ffxs_pkg::state_t            state_r, state_nxt;
  logic [AW-1:0]               oldest_r, oldest_nxt;
  logic [CW-1:0]               fill_r, fill_nxt;
  logic [CW-1:0]               idx_r, idx_nxt;     // offset of the byte in rd_data
  logic [ffxs_pkg::BYTE_W-1:0] chk_r, chk_nxt;

  // output register
  logic                        out_valid_r, out_valid_nxt;
  logic [ffxs_pkg::BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic [ffxs_pkg::POS_W-1:0]  out_pos_r, out_pos_nxt;
  logic                        out_end_r, out_end_nxt;

  // window port
  ffxs_pkg::win_ctl_t          win_ctl;
  logic [CW-1:0]               wr_off, rd_off;
  logic [ffxs_pkg::BYTE_W-1:0] rd_data;

  logic [CMPW-1:0] fill_x, len_x, last_x, idx_x;
  logic            len_ok, have_frame, at_last, tail_bad;
  logic            in_fire, out_free;
  logic [SW-1:0]   step, oldest_sum;
  logic [AW-1:0]   oldest_adv;
  logic            adv_one;

  ffxs_window #(
    .MAX_FRAME (MAX_FRAME),
    .AW        (AW),
    .CW        (CW)
  ) u_window (
    .clk         (clk),
    .ctl         (win_ctl),
    .oldest_slot (oldest_r),
    .wr_off      (wr_off),
    .wr_data     (in_rx_byte),
    .rd_off      (rd_off),
    .rd_data     (rd_data)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ffxs_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;

  assign out_valid         = out_valid_r;
  assign out_frame_byte    = out_byte_r;
  assign out_byte_position = out_pos_r;
  assign out_frame_end     = out_end_r;
  assign out_free          = !out_valid_r || out_ready;

  assign fill_x     = CMPW'(fill_r);
  assign len_x      = CMPW'(length_r);
  assign last_x     = len_x - CMPW'(1);
  assign idx_x      = CMPW'(idx_r);
  assign len_ok     = (len_x >= CMPW'(ffxs_pkg::MIN_LEN)) && (len_x <= CMPW'(MAX_FRAME));
  assign have_frame = (fill_x >= len_x);
  assign at_last    = (idx_x == last_x);
  assign tail_bad   = (tail_r != '0) && (rd_data != tail_r[ffxs_pkg::BYTE_W-1:0]);

  // oldest slot advance: by one on a drop or a full-window write, by the frame length after an emit
  assign step       = adv_one ? SW'(1) : SW'(length_r);
  assign oldest_sum = SW'(oldest_r) + step;
  assign oldest_adv = (oldest_sum >= SW'(MAX_FRAME)) ? AW'(oldest_sum - SW'(MAX_FRAME))
                                                     : AW'(oldest_sum);

  always_comb begin
    state_nxt     = state_r;
    oldest_nxt    = oldest_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    chk_nxt       = chk_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_pos_nxt   = out_pos_r;
    out_end_nxt   = out_end_r;
    win_ctl       = '0;
    wr_off        = fill_r;
    rd_off        = '0;
    adv_one       = 1'b1;

    unique case (state_r)
      ffxs_pkg::S_IDLE: begin
        if (in_fire) begin
          win_ctl.wr_en = 1'b1;
          if (fill_r == CW'(MAX_FRAME)) begin
            // full window: offset MAX_FRAME from the current oldest lands on
            // the oldest slot, which is overwritten; fill stays
            oldest_nxt = oldest_adv;
          end else begin
            fill_nxt = fill_r + CW'(1);
          end
          if (len_ok) begin
            state_nxt = ffxs_pkg::S_CHECK;
          end
        end
      end

      ffxs_pkg::S_CHECK: begin
        // header candidate read; the write path is idle here, so no overlap
        if (have_frame) begin
          win_ctl.rd_en = 1'b1;
          rd_off        = '0;
          state_nxt     = ffxs_pkg::S_HDR;
        end else begin
          state_nxt = ffxs_pkg::S_IDLE;
        end
      end

      ffxs_pkg::S_HDR: begin
        if (rd_data != header_r) begin
          oldest_nxt = oldest_adv;
          fill_nxt   = fill_r - CW'(1);
          state_nxt  = ffxs_pkg::S_CHECK;
        end else begin
          win_ctl.rd_en = 1'b1;
          rd_off        = CW'(1);
          idx_nxt       = CW'(1);
          chk_nxt       = '0;
          state_nxt     = ffxs_pkg::S_SCAN;
        end
      end

      ffxs_pkg::S_SCAN: begin
        if (!at_last) begin
          chk_nxt       = chk_r ^ rd_data;
          idx_nxt       = idx_r + CW'(1);
          win_ctl.rd_en = 1'b1;
          rd_off        = idx_r + CW'(1);
        end else if ((chk_r != rd_data) || tail_bad) begin
          oldest_nxt = oldest_adv;
          fill_nxt   = fill_r - CW'(1);
          state_nxt  = ffxs_pkg::S_CHECK;
        end else begin
          idx_nxt   = '0;
          state_nxt = ffxs_pkg::S_EMIT_RD;
        end
      end

      ffxs_pkg::S_EMIT_RD: begin
        win_ctl.rd_en = 1'b1;
        rd_off        = idx_r;
        state_nxt     = ffxs_pkg::S_EMIT_WB;
      end

      ffxs_pkg::S_EMIT_WB: begin
        // rd_data holds until the output register frees up
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = rd_data;
          out_pos_nxt   = ffxs_pkg::POS_W'(idx_r);
          out_end_nxt   = at_last;
          if (at_last) begin
            adv_one    = 1'b0;
            oldest_nxt = oldest_adv;
            fill_nxt   = fill_r - CW'(length_r);
            state_nxt  = ffxs_pkg::S_IDLE;
          end else begin
            idx_nxt   = idx_r + CW'(1);
            state_nxt = ffxs_pkg::S_EMIT_RD;
          end
        end
      end

      default: begin
        state_nxt = ffxs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffxs_pkg::S_IDLE;
      oldest_r    <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    chk_r      <= chk_nxt;
    out_byte_r <= out_byte_nxt;
    out_pos_r  <= out_pos_nxt;
    out_end_r  <= out_end_nxt;
  end

  // configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= ffxs_pkg::HEADER_RST;
      tail_r   <= ffxs_pkg::TAIL_RST;
      length_r <= ffxs_pkg::LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ffxs_pkg::REG_HEADER: header_r <= cfg_data[ffxs_pkg::BYTE_W-1:0];
        ffxs_pkg::REG_TAIL:   tail_r   <= cfg_data[ffxs_pkg::TAIL_W-1:0];
        ffxs_pkg::REG_LENGTH: length_r <= cfg_data[ffxs_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/tb_fixed_frame_xor_sync.sv
// Self-checking bench for fixed_frame_xor_sync: random byte streams with embedded
// frames, a frame scoreboard class, and randomized stalls on both channels.
// Depends on ffxs_pkg and the fixed_frame_xor_sync RTL.
`timescale 1ns / 1ps

module tb_fixed_frame_xor_sync;
  import ffxs_pkg::*;

  localparam int WIN_DEPTH    = 32;
  localparam int SETTLE_CYC   = 1300;     // worst scan over a full window, with margin
  localparam int LIMIT_CYC    = 1000000;
  localparam int RANDOM_ITEMS = 150;

  // unused index: writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // Frame scoreboard: tracks the byte window and config, predicts frame bytes
  class frame_board;
    typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic [POS_W-1:0]  pos;
      logic              last;
    } frame_beat_t;

    logic [BYTE_W-1:0] window [WIN_DEPTH];
    logic [POS_W-1:0]  head;
    logic [LEN_W-1:0]  fill;
    logic [BYTE_W-1:0] hdr_byte;
    logic [TAIL_W-1:0] tail_val;
    logic [LEN_W-1:0]  len_cfg;
    frame_beat_t       beats_due [$];
    int                errors;
    int                frames;
    int                beats_out;

    function new();
      head      = '0;
      fill      = '0;
      hdr_byte  = HEADER_RST;
      tail_val  = TAIL_RST;
      len_cfg   = LENGTH_RST;
      errors    = 0;
      frames    = 0;
      beats_out = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
      case (idx)
        REG_HEADER: hdr_byte  = d[BYTE_W-1:0];
        REG_TAIL:   tail_val  = d[TAIL_W-1:0];
        REG_LENGTH: len_cfg   = d[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [BYTE_W-1:0] byte_at(int offset);
      logic [POS_W-1:0] slot;
      slot = head + offset[POS_W-1:0];
      return window[slot];
    endfunction

    function void drop_oldest();
      if (fill != '0) begin
        head = head + 1'b1;
        fill = fill - 1'b1;
      end
    endfunction

    // one accepted input byte; queues the frame it completes, if any
    function void absorb_rx_byte(logic [BYTE_W-1:0] b);
      logic [POS_W-1:0]  slot;
      logic [BYTE_W-1:0] chk;
      frame_beat_t       beat;
      int                len;
      if (int'(fill) >= WIN_DEPTH) drop_oldest();
      slot = head + fill[POS_W-1:0];
      window[slot] = b;
      fill = fill + 1'b1;
      len = int'(len_cfg);
      if (len < int'(MIN_LEN) || len > WIN_DEPTH) return;
      while (int'(fill) >= len) begin
        if (byte_at(0) != hdr_byte) begin
          drop_oldest();
          continue;
        end
        chk = '0;
        for (int i = 1; i < len - 1; i++) chk ^= byte_at(i);
        if (chk != byte_at(len - 1) ||
            (tail_val != '0 && byte_at(len - 1) != tail_val[BYTE_W-1:0])) begin
          drop_oldest();
          continue;
        end
        for (int i = 0; i < len; i++) begin
          beat.data = byte_at(i);
          beat.pos  = i[POS_W-1:0];
          beat.last = (i == len - 1);
          beats_due.push_back(beat);
        end
        head = head + len[POS_W-1:0];
        fill = fill - len[LEN_W-1:0];
        frames++;
        return;
      end
    endfunction

    function void check_beat(logic [BYTE_W-1:0] data, logic [POS_W-1:0] pos, logic last);
      frame_beat_t want;
      beats_out++;
      if (beats_due.size() == 0) begin
        $error("frame byte %0h at position %0d arrived with no frame due", data, pos);
        errors++;
        return;
      end
      want = beats_due.pop_front();
      if (data !== want.data) begin
        $error("frame_byte: expected %0h, got %0h", want.data, data);
        errors++;
      end
      if (pos !== want.pos) begin
        $error("byte_position: expected %0d, got %0d", want.pos, pos);
        errors++;
      end
      if (last !== want.last) begin
        $error("frame_end: expected %0b, got %0b", want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return beats_due.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [BYTE_W-1:0]    in_rx_byte;
  logic                 out_valid;
  logic                 out_ready;
  logic [BYTE_W-1:0]    out_frame_byte;
  logic [POS_W-1:0]     out_byte_position;
  logic                 out_frame_end;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  frame_board board = new();
  int         rx_sent  = 0;   // input items accepted
  int         settings = 0;   // register settings applied
  bit         src_steady = 1'b0;

  fixed_frame_xor_sync #(.MAX_FRAME(WIN_DEPTH)) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_byte    (out_frame_byte),
    .out_byte_position (out_byte_position),
    .out_frame_end     (out_frame_end),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake or missing frame byte ends up here
  initial begin
    repeat (LIMIT_CYC) @(posedge clk);
    $display("FAIL fixed_frame_xor_sync");
    $finish;
  end

  // Monitor: everything is sampled at the rising edge. Config and input items
  // update the prediction before any result of the same edge is checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) board.absorb_rx_byte(in_rx_byte);
      if (out_valid && out_ready)
        board.check_beat(out_frame_byte, out_byte_position, out_frame_end);
    end
  end

  // Result sink: mostly short stalls, a few long ones, and stretches of
  // constant ready. One assignment to out_ready per falling edge.
  initial begin
    int  stall_left;
    int  r;
    bit  sink_steady;
    stall_left  = 0;
    sink_steady = 1'b0;
    out_ready   = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 299) == 0) sink_steady = ~sink_steady;
      if (sink_steady) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_ready <= 1'b1;
        end else if (r < 93) begin
          out_ready  <= 1'b0;
          stall_left = $urandom_range(0, 2);
        end else begin
          out_ready  <= 1'b0;
          stall_left = $urandom_range(10, 40);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (src_steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [BYTE_W-1:0] pick_header();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'h00;
    if (r < 30) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic logic [TAIL_W-1:0] pick_tail();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 16'h0000;
    if (r < 65) return 16'hFFFF;
    if (r < 75) return 16'h0100;   // tail check on, low byte zero
    return 16'($urandom);
  endfunction

  // Drive one input item; returns at the edge where it is taken.
  // A zero gap keeps valid high straight into the next item.
  task automatic push_rx_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    rx_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Sender pauses until every predicted frame byte is out, then gives the
  // block time to finish scanning bytes left in the window.
  task automatic wait_frames_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Upper data bits beyond the header and length widths carry junk on purpose
  task automatic set_config(input logic [BYTE_W-1:0] h, input logic [TAIL_W-1:0] t,
                            input logic [LEN_W-1:0] l);
    wait_frames_drained();
    write_reg(REG_HEADER, {8'($urandom), h});
    write_reg(REG_TAIL, t);
    write_reg(REG_LENGTH, {10'($urandom), l});
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  task automatic write_spare();
    write_reg(REG_SPARE, 16'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Well-formed frame for the current config; with corrupt set, one bit
  // somewhere in it is flipped so the check fails at that alignment.
  task automatic send_frame(input int len, input bit corrupt);
    logic [BYTE_W-1:0] body [WIN_DEPTH];
    logic [BYTE_W-1:0] chk;
    int                spot;
    body[0] = board.hdr_byte;
    for (int i = 1; i < len - 1; i++) body[i] = 8'($urandom);
    if (board.tail_val != '0) begin
      // steer the check byte onto the tail value
      chk = '0;
      for (int i = 1; i < len - 2; i++) chk ^= body[i];
      body[len - 2] = chk ^ board.tail_val[BYTE_W-1:0];
    end
    chk = '0;
    for (int i = 1; i < len - 1; i++) chk ^= body[i];
    body[len - 1] = chk;
    if (corrupt) begin
      spot = $urandom_range(0, len - 1);
      body[spot] ^= 8'(1 << $urandom_range(0, 7));
    end
    for (int i = 0; i < len; i++) push_rx_byte(body[i]);
  endtask

  // Random bytes, a quarter of them equal to the header to seed false starts
  task automatic send_noise(input int n);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) push_rx_byte(board.hdr_byte);
      else push_rx_byte(8'($urandom));
    end
  endtask

  initial begin
    int len;
    int act;
    int phase_start;
    int random_items;
    int odd_lens [5];
    odd_lens     = '{0, 1, 2, 33, 63};
    random_items = 0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: one frame under reset defaults (header 0, length 13, no tail)
    send_frame(13, 1'b0);

    // Minimum length: all-zero and all-ones payloads
    set_config(8'hA5, 16'h0000, MIN_LEN);
    push_rx_byte(8'hA5); push_rx_byte(8'h00); push_rx_byte(8'h00);
    push_rx_byte(8'hA5); push_rx_byte(8'hFF); push_rx_byte(8'hFF);

    // Header and tail at their maximum: a good frame, then one that passes
    // the XOR check but fails the tail check
    set_config(8'hFF, 16'hFFFF, 6'd4);
    push_rx_byte(8'hFF); push_rx_byte(8'h0F); push_rx_byte(8'hF0); push_rx_byte(8'hFF);
    push_rx_byte(8'hFF); push_rx_byte(8'h00); push_rx_byte(8'h00); push_rx_byte(8'h00);

    // Lengths that never emit: too short and too long. Together these put
    // enough bytes in to wrap the window, so the oldest bytes get overwritten.
    foreach (odd_lens[k]) begin
      set_config(pick_header(), pick_tail(), odd_lens[k][LEN_W-1:0]);
      send_noise(7);
    end
    // Window is full; a short length now scans the leftover bytes first
    set_config(board.hdr_byte, 16'h0000, 6'd5);
    write_spare();
    send_frame(5, 1'b0);
    send_frame(5, 1'b0);

    // Largest frame the window can hold
    set_config(pick_header(), pick_tail(), 6'd32);
    send_frame(32, 1'b0);
    send_frame(32, 1'b1);
    send_frame(32, 1'b0);

    // Random phases: mostly good frames, with broken frames and noise
    while (random_items < RANDOM_ITEMS) begin
      act = $urandom_range(0, 99);
      if (act < 70) len = $urandom_range(3, 8);
      else if (act < 90) len = $urandom_range(9, 16);
      else len = $urandom_range(17, 32);
      set_config(pick_header(), pick_tail(), len[LEN_W-1:0]);
      if ($urandom_range(0, 4) == 0) write_spare();
      src_steady  = ($urandom_range(0, 3) == 0);
      phase_start = rx_sent;
      while (rx_sent - phase_start < 40) begin
        act = $urandom_range(0, 99);
        if (act < 70) send_frame(len, 1'b0);
        else if (act < 85) send_frame(len, 1'b1);
        else send_noise($urandom_range(1, 5));
      end
      random_items += rx_sent - phase_start;
    end

    wait_frames_drained();
    $display("Run covered %0d input bytes, %0d frames (%0d frame bytes) over %0d settings",
             rx_sent, board.frames, board.beats_out, settings);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASS fixed_frame_xor_sync");
    end else begin
      $display("FAIL fixed_frame_xor_sync");
    end
    $finish;
  end

endmodule

// File: sim.f
src/ffxs_pkg.sv
src/ffxs_window.sv
src/fixed_frame_xor_sync.sv
tb/sv/tb_fixed_frame_xor_sync.sv
